// File: hdl/tss_pkg.sv
// tss_pkg: types, constants and helper functions for the taylor series block
// used by tss_mul, tss_div and taylor_series_sin_exp; no dependencies
`default_nettype none

package tss_pkg;

  // fixed point and series limits
  localparam int FRAC_BITS = 24;
  localparam int MAX_TERMS = 64;
  localparam int CNT_W     = 7;    // term index, holds 0..MAX_TERMS
  localparam int X_W       = 30;   // input point
  localparam int XSQ_W     = 59;   // |x|^2 (2^58 at most)
  localparam int MAG_W     = 63;   // term magnitude
  localparam int SUM_W     = 64;   // signed sums
  localparam int PROD_W    = MAG_W + XSQ_W;  // 122 bit exact product
  localparam int DVD_W     = 73;   // product after the fixed point shift
  localparam int DVS_W     = 15;   // divisor, (2k+2)(2k+3) <= 17030
  localparam int TOL_W     = 25;
  localparam int STEP_W    = 7;    // unit step counters

  localparam logic [TOL_W-1:0] TOL_RESET = 25'd16777;
  localparam logic [MAG_W-1:0] MAG_MAX   = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0] ONE_Q24   = MAG_W'(1) << FRAC_BITS;

  // register map: word index taken from paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_DIV,
    ST_EVAL,
    ST_FIN
  } state_t;

  // status of a shared serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // signed saturating add of a sign/magnitude term to a sum
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [MAG_W-1:0] mag,
                                               input logic neg);
    logic [SUM_W-1:0] b;
    logic [SUM_W:0]   s;
    b = neg ? (SUM_W'(0) - {1'b0, mag}) : {1'b0, mag};
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/taylor_series_sin_exp.sv
// taylor_series_sin_exp: sine / exponential taylor series with a term sequencer
// uses tss_pkg, tss_mul and tss_div
//
//  channel   direction  ports
//  in_       input      in_valid, in_stall, in_action, in_x_value
//  out_      output     out_valid, out_stall, out_partial_sum, out_next_sum,
//                       out_term_count, out_not_converged
//  config    apb        psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// each term runs a serial multiply, then a serial divide, then the control states;
// the serial multiplier and divider each handle one bit per cycle
// rst_n is synchronous; tolerance resets to 16777
// in_stall is high while an item is in work; a stalled result holds the
// finished item until out_stall falls
`default_nettype none

module taylor_series_sin_exp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_action,
  input  wire logic signed [29:0]          in_x_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [63:0]               out_partial_sum,
  output logic signed [63:0]               out_next_sum,
  output logic        [6:0]                out_term_count,
  output logic                             out_not_converged,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic   [2:0]                paddr,
  input  wire logic   [31:0]               pwdata,
  output logic        [31:0]               prdata,
  output logic                             pready
);

  tss_pkg::state_t state_r, state_nxt;

  logic [tss_pkg::TOL_W-1:0]   tol_r;
  logic                        is_exp_r;
  logic                        xneg_r;
  logic [tss_pkg::X_W-1:0]     xmag_r;
  logic [tss_pkg::XSQ_W-1:0]   xsq_r;
  logic [tss_pkg::MAG_W-1:0]   tmag_r;
  logic                        tneg_r;
  logic [tss_pkg::SUM_W-1:0]   sum_r;
  logic [tss_pkg::SUM_W-1:0]   next_r;
  logic [tss_pkg::CNT_W-1:0]   i_r;
  logic                        flag_r;
  logic [tss_pkg::DVS_W-1:0]   dvs_r;
  logic                        out_valid_r;
  logic [tss_pkg::SUM_W-1:0]   out_psum_r;
  logic [tss_pkg::SUM_W-1:0]   out_nsum_r;
  logic [tss_pkg::CNT_W-1:0]   out_cnt_r;
  logic                        out_flag_r;

  logic                        in_xfer;
  logic                        out_free;
  logic                        mul_start;
  logic                        div_start;
  tss_pkg::unit_stat_t         mul_st;
  tss_pkg::unit_stat_t         div_st;
  logic [tss_pkg::PROD_W-1:0]  prod;
  logic [tss_pkg::DVD_W-1:0]   dividend;
  logic [tss_pkg::DVD_W-1:0]   quot;
  logic [tss_pkg::XSQ_W-1:0]   mplier;
  logic [tss_pkg::MAG_W-1:0]   nmag;
  logic                        nneg;
  logic [tss_pkg::SUM_W-1:0]   nsum;
  logic                        stop_tol;
  logic                        stop_lim;
  logic [tss_pkg::X_W-1:0]     in_xmag;
  logic [tss_pkg::CNT_W:0]     two_k2;
  logic [15:0]                 sin_dvs;
  logic                        cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= tss_pkg::TOL_RESET;
    end else if (cfg_wr && (paddr[2] == tss_pkg::REG_TOLERANCE)) begin
      tol_r <= pwdata[tss_pkg::TOL_W-1:0];
    end
  end
  assign prdata = (paddr[2] == tss_pkg::REG_TOLERANCE) ?
                  {{(32-tss_pkg::TOL_W){1'b0}}, tol_r} : 32'd0;

  // handshakes
  assign in_stall = (state_r != tss_pkg::ST_IDLE);
  assign in_xfer  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tss_pkg::ST_IDLE:  if (in_xfer) state_nxt = tss_pkg::ST_START;
      tss_pkg::ST_START: state_nxt = tss_pkg::ST_MUL;
      tss_pkg::ST_MUL:   if (mul_st.done) state_nxt = tss_pkg::ST_DIV;
      tss_pkg::ST_DIV:   if (div_st.done) state_nxt = tss_pkg::ST_EVAL;
      tss_pkg::ST_EVAL: begin
        if (stop_tol || stop_lim) state_nxt = tss_pkg::ST_FIN;
        else                      state_nxt = tss_pkg::ST_START;
      end
      tss_pkg::ST_FIN:   if (out_free) state_nxt = tss_pkg::ST_IDLE;
      default:           state_nxt = tss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tss_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // unit start pulses
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      tss_pkg::ST_START: mul_start = 1'b1;
      tss_pkg::ST_MUL:   div_start = mul_st.done;
      default: begin
        mul_start = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  // input magnitude and divisor for the current term
  assign in_xmag = in_x_value[tss_pkg::X_W-1] ? (tss_pkg::X_W'(0) - in_x_value)
                                              : in_x_value;
  assign two_k2  = {i_r, 1'b0} + 8'd2;
  assign sin_dvs = {8'd0, two_k2} * {8'd0, two_k2 + 8'd1};
  assign mplier  = is_exp_r ? {{(tss_pkg::XSQ_W-tss_pkg::X_W){1'b0}}, xmag_r} : xsq_r;

  // drop the fixed point fraction of the product
  assign dividend = is_exp_r ? prod[tss_pkg::FRAC_BITS +: tss_pkg::DVD_W]
                             : prod[2*tss_pkg::FRAC_BITS +: tss_pkg::DVD_W];

  // new term, its sign and the sum that includes it
  always_comb begin
    nmag = (quot[tss_pkg::DVD_W-1:tss_pkg::MAG_W] != '0) ? tss_pkg::MAG_MAX
                                                         : quot[tss_pkg::MAG_W-1:0];
    nneg = is_exp_r ? (tneg_r ^ xneg_r) : ~tneg_r;
    if (nmag == '0) nneg = 1'b0;
    nsum     = tss_pkg::sat_add(sum_r, nmag, nneg);
    stop_tol = (nmag <= {{(tss_pkg::MAG_W-tss_pkg::TOL_W){1'b0}}, tol_r});
    stop_lim = (i_r >= tss_pkg::CNT_W'(tss_pkg::MAX_TERMS));
  end

  // series datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      is_exp_r <= in_action;
      xneg_r   <= in_x_value[tss_pkg::X_W-1];
      xmag_r   <= in_xmag;
      xsq_r    <= tss_pkg::XSQ_W'({30'd0, in_xmag} * {30'd0, in_xmag});
      i_r      <= '0;
      flag_r   <= 1'b0;
      if (in_action) begin
        tmag_r <= tss_pkg::ONE_Q24;
        tneg_r <= 1'b0;
        sum_r  <= {1'b0, tss_pkg::ONE_Q24};
      end else begin
        tmag_r <= {{(tss_pkg::MAG_W-tss_pkg::X_W){1'b0}}, in_xmag};
        tneg_r <= in_x_value[tss_pkg::X_W-1];
        sum_r  <= {{(tss_pkg::SUM_W-tss_pkg::X_W){in_x_value[tss_pkg::X_W-1]}},
                   in_x_value};
      end
    end else begin
      case (state_r)
        tss_pkg::ST_START: begin
          dvs_r <= is_exp_r ? tss_pkg::DVS_W'({1'b0, i_r} + 8'd1)
                            : sin_dvs[tss_pkg::DVS_W-1:0];
        end
        tss_pkg::ST_EVAL: begin
          next_r <= nsum;
          if (!stop_tol) begin
            if (stop_lim) begin
              flag_r <= 1'b1;
            end else begin
              sum_r  <= nsum;
              tmag_r <= nmag;
              tneg_r <= nneg;
              i_r    <= i_r + 1'b1;
            end
          end
        end
        default: begin
          i_r <= i_r;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == tss_pkg::ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == tss_pkg::ST_FIN) && out_free) begin
      out_psum_r <= sum_r;
      out_nsum_r <= next_r;
      out_cnt_r  <= i_r;
      out_flag_r <= flag_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_partial_sum   = out_psum_r;
  assign out_next_sum      = out_nsum_r;
  assign out_term_count    = out_cnt_r;
  assign out_not_converged = out_flag_r;

  // shared serial units
  tss_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (tmag_r),
    .mplier (mplier),
    .stat   (mul_st),
    .prod   (prod)
  );

  tss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dvs_r),
    .stat     (div_st),
    .quot     (quot)
  );

`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_st.busy && div_st.busy))
    else $error("multiplier and divider busy together");

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tss_pkg::ST_IDLE) |-> (i_r <= tss_pkg::CNT_W'(tss_pkg::MAX_TERMS)))
    else $error("term index beyond limit");

  a_flag_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flag_r |-> (out_cnt_r == tss_pkg::CNT_W'(tss_pkg::MAX_TERMS)))
    else $error("not_converged without reaching the term limit");

  a_div_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> $past(state_r) == tss_pkg::ST_START || mul_st.done)
    else $error("divider started without a finished product");
`endif

endmodule

`default_nettype wire

// File: hdl/tss_mul.sv
// tss_mul: shift-add multiplier, one multiplier bit per cycle
// uses tss_pkg for widths and the unit status struct
`default_nettype none

module tss_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [tss_pkg::MAG_W-1:0]    mcand,
  input  wire logic [tss_pkg::XSQ_W-1:0]    mplier,
  output tss_pkg::unit_stat_t               stat,
  output logic      [tss_pkg::PROD_W-1:0]   prod
);

  localparam int HI_W = tss_pkg::MAG_W + 1;
  localparam int P_W  = HI_W + tss_pkg::XSQ_W;

  logic [P_W-1:0]                  p_r;
  logic [tss_pkg::MAG_W-1:0]       a_r;
  logic [tss_pkg::STEP_W-1:0]      cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [HI_W:0]                   hi_sum;

  // add the multiplicand into the upper half when the low bit is set
  always_comb begin
    hi_sum = {1'b0, p_r[P_W-1 -: HI_W]} +
             (p_r[0] ? {2'b0, a_r} : {(HI_W+1){1'b0}});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= tss_pkg::STEP_W'(tss_pkg::XSQ_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == tss_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (start) begin
      p_r <= {{HI_W{1'b0}}, mplier};
      a_r <= mcand;
    end else if (busy_r) begin
      p_r <= {hi_sum, p_r[tss_pkg::XSQ_W-1:1]};
    end
  end

  assign prod      = p_r[tss_pkg::PROD_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// File: hdl/tss_div.sv
// tss_div: restoring divider, one quotient bit per cycle
// uses tss_pkg for widths and the unit status struct
`default_nettype none

module tss_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tss_pkg::DVD_W-1:0]   dividend,
  input  wire logic [tss_pkg::DVS_W-1:0]   divisor,
  output tss_pkg::unit_stat_t              stat,
  output logic      [tss_pkg::DVD_W-1:0]   quot
);

  logic [tss_pkg::DVD_W-1:0]   d_r;
  logic [tss_pkg::DVS_W-1:0]   dvs_r;
  logic [tss_pkg::DVS_W-1:0]   rem_r;
  logic [tss_pkg::STEP_W-1:0]  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [tss_pkg::DVS_W:0]     r2;
  logic [tss_pkg::DVS_W:0]     diff;
  logic                        ge;

  // trial subtract of the divisor
  always_comb begin
    r2   = {rem_r, d_r[tss_pkg::DVD_W-1]};
    diff = r2 - {1'b0, dvs_r};
    ge   = (r2 >= {1'b0, dvs_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= tss_pkg::STEP_W'(tss_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == tss_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[tss_pkg::DVS_W-1:0] : r2[tss_pkg::DVS_W-1:0];
      d_r   <= {d_r[tss_pkg::DVD_W-2:0], ge};
    end
  end

  assign quot      = d_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// File: test/taylor_series_sin_exp_tb.sv
// taylor_series_sin_exp_tb: self-checking bench for the sine / exponential series block
// depends on tss_pkg and taylor_series_sin_exp; a scoreboard class predicts each result
`default_nettype none

class series_scoreboard;
  typedef struct {
    logic signed [63:0] psum;
    logic signed [63:0] nsum;
    logic [6:0]         cnt;
    logic               nc;
  } series_result_t;

  series_result_t pending_q[$];
  logic [24:0]    tol;
  int             errors;
  int             checked;

  function new();
    tol = tss_pkg::TOL_RESET;
    errors = 0;
    checked = 0;
  endfunction

  // floor(t * mul / 2^sh / div) saturated to 63 bits
  function logic [62:0] scale(logic [62:0] t, logic [58:0] mul, int sh, logic [14:0] dv);
    logic [121:0] prod;
    logic [121:0] quo;
    prod = {59'd0, t} * {63'd0, mul};
    quo = (prod >> sh) / {107'd0, dv};
    if (quo > {59'd0, {63{1'b1}}}) scale = {63{1'b1}};
    else scale = quo[62:0];
  endfunction

  function logic signed [63:0] sadd(logic signed [63:0] a, logic [62:0] mag, logic neg);
    logic signed [64:0] s;
    s = neg ? ($signed({a[63], a}) - $signed({2'b00, mag}))
            : ($signed({a[63], a}) + $signed({2'b00, mag}));
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) sadd = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (s < -65'sh0_8000_0000_0000_0000) sadd = 64'sh8000_0000_0000_0000;
    else sadd = s[63:0];
  endfunction

  // note an accepted input and predict its result
  function void note_input(logic act, logic [29:0] x);
    logic           xneg, tneg, nneg, flag;
    logic [29:0]    xmag;
    logic [58:0]    xsq;
    logic [62:0]    tmag, nmag;
    logic signed [63:0] psum, nsum;
    int             i;
    series_result_t r;
    xneg = x[29];
    xmag = xneg ? (30'd0 - x) : x;
    xsq = {29'd0, xmag} * {29'd0, xmag};
    if (act) begin
      tmag = 63'd1 << 24;
      tneg = 1'b0;
    end else begin
      tmag = {33'd0, xmag};
      tneg = xneg;
    end
    psum = sadd(64'sd0, tmag, tneg);
    i = 0;
    flag = 1'b0;
    forever begin
      if (act) begin
        nmag = scale(tmag, {29'd0, xmag}, 24, 15'(i + 1));
        nneg = tneg ^ xneg;
      end else begin
        nmag = scale(tmag, xsq, 48, 15'((2 * i + 2) * (2 * i + 3)));
        nneg = !tneg;
      end
      if (nmag == 0) nneg = 1'b0;
      nsum = sadd(psum, nmag, nneg);
      if (nmag <= {38'd0, tol}) break;
      if (i >= tss_pkg::MAX_TERMS) begin
        flag = 1'b1;
        break;
      end
      psum = nsum;
      tmag = nmag;
      tneg = nneg;
      i++;
    end
    r.psum = psum;
    r.nsum = nsum;
    r.cnt = 7'(i);
    r.nc = flag;
    pending_q.push_back(r);
  endfunction

  // check an accepted result against the oldest prediction
  function void check_result(logic signed [63:0] ps, logic signed [63:0] ns,
                             logic [6:0] cnt, logic nc);
    series_result_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result partial_sum %0d", $time, ps);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    checked++;
    if (ps !== e.psum) begin
      $display("%0t: partial_sum expected %0d actual %0d", $time, e.psum, ps);
      errors++;
    end
    if (ns !== e.nsum) begin
      $display("%0t: next_sum expected %0d actual %0d", $time, e.nsum, ns);
      errors++;
    end
    if (cnt !== e.cnt) begin
      $display("%0t: term_count expected %0d actual %0d", $time, e.cnt, cnt);
      errors++;
    end
    if (nc !== e.nc) begin
      $display("%0t: not_converged expected %0b actual %0b", $time, e.nc, nc);
      errors++;
    end
  endfunction
endclass

module taylor_series_sin_exp_tb;

  localparam int IDLE_LIMIT = 200000;
  localparam logic ACT_SIN = 1'b0;
  localparam logic ACT_EXP = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = 1'b0;
  logic signed [29:0] in_x_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] out_partial_sum, out_next_sum;
  logic [6:0] out_term_count;
  logic out_not_converged;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  series_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int idle_cycles = 0;
  int sent = 0;
  int sin_cnt = 0, exp_cnt = 0;

  taylor_series_sin_exp i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stall, long hold-off, and checking on each transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_partial_sum, out_next_sum, out_term_count, out_not_converged);
    end
    out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** taylor_series_sin_exp: FAILED **");
      $finish;
    end
  end

  task automatic write_tolerance(logic [24:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {tss_pkg::REG_TOLERANCE, 2'b00};
    pwdata <= {7'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.tol = val;
  endtask

  // one input transfer, with optional idle cycles before it
  task automatic send_item(logic act, logic [29:0] x);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_x_value <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(act, x);
    sent++;
    if (act) exp_cnt++;
    else sin_cnt++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly small magnitudes, some across the whole field
  function automatic logic [29:0] rand_x();
    case ($urandom_range(3))
      0: rand_x = 30'($urandom);
      1: rand_x = 30'($signed(30'($urandom_range(32'h0400_0000)))) *
                  ($urandom_range(1) ? 30'sd1 : -30'sd1);
      default: rand_x = 30'($urandom_range(32'h0200_0000)) ^
                        ($urandom_range(1) ? 30'h3FFF_FFFF : 30'h0);
    endcase
  endfunction

  initial begin
    logic [29:0] dir_x[10];
    dir_x = '{30'h0, 30'h1, 30'h3FFF_FFFF, 30'h0100_0000, 30'h3F00_0000,
              30'h1000_0000, 30'h3000_0000, 30'h1FFF_FFFF, 30'h2000_0000,
              30'h0324_3F6A};
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes for both series at reset tolerance
    foreach (dir_x[k]) begin
      send_item(ACT_SIN, dir_x[k]);
      send_item(ACT_EXP, dir_x[k]);
    end
    drain();
    // tolerance of zero, of 1.0 in Q24 and of one lsb
    write_tolerance(25'd0);
    send_item(ACT_SIN, 30'h0100_0000);
    send_item(ACT_EXP, 30'h1000_0000);
    drain();
    write_tolerance(25'h100_0000);
    send_item(ACT_SIN, 30'h0200_0000);
    send_item(ACT_EXP, 30'h3FFF_FFFF);
    drain();
    write_tolerance(25'd1);
    send_item(ACT_EXP, 30'h0100_0000);
    drain();

    // random phases with several tolerances and idling patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_tolerance(ph == 4 ? tss_pkg::TOL_RESET
                              : 25'($urandom_range(25'h1FF_FFFF, 0) & 25'h00F_FFFF));
      if (ph == 4) begin
        // receiver holds off while the sender keeps offering
        fork
          begin
            hold_recv = 1'b1;
            repeat (30000) @(posedge clk);
            hold_recv = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 25; n++) send_item(1'($urandom), rand_x());
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    $display("run covered %0d items (%0d sine, %0d exp), %0d results checked",
             sent, sin_cnt, exp_cnt, sb.checked);
    $display("tolerance swept from zero to one, with stall and idle phases");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** taylor_series_sin_exp: PASSED **");
    end else begin
      $display("** taylor_series_sin_exp: FAILED **");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
hdl/tss_pkg.sv
hdl/tss_mul.sv
hdl/tss_div.sv
hdl/taylor_series_sin_exp.sv
test/taylor_series_sin_exp_tb.sv
